[rtl/text_mode_terminal_buffer_core_macros.svh]
// Assertion macros for the checker file of the text buffer core.
// Depends on nothing; include with the bare file name.
`ifndef TEXT_MODE_TERMINAL_BUFFER_CORE_MACROS_SVH
`define TEXT_MODE_TERMINAL_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TMB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text buffer check failed");

// Next-cycle implication, disabled while reset is low.
`define TMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text buffer check failed");

`endif

[rtl/tmb_pkg.sv]
// Shared types and constants of the text buffer core.
// Depends on nothing; imported by the controller, datapath and top level.
package tmb_pkg;

    localparam int COL_W      = 6;
    localparam int ROW_W      = 5;
    localparam int MAX_COLS   = 1 << COL_W;
    localparam int MAX_ROWS   = 1 << ROW_W;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int CFG_COLS_W = 7;
    localparam int CFG_ROWS_W = 6;

    localparam logic [7:0] CODE_SPACE = 8'd32;
    localparam logic [7:0] CODE_NL    = 8'd10;
    localparam logic [7:0] CODE_CR    = 8'd13;

    // Glyph geometry: 11x13 pixels, 10 glyphs per font sheet row.
    localparam int GLYPH_W       = 11;
    localparam int GLYPH_H       = 13;
    localparam int SHEET_PER_ROW = 10;
    // Divide by 10 as multiply by 205 then shift 11 (exact below 1029).
    localparam int DIV10_MUL     = 205;
    localparam int DIV10_SHIFT   = 11;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_MOVE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RD_DATA,
        ST_RD_COORD,
        ST_CLEAR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_direct;
        logic load_regs;
        logic rd_stage1;
        logic rd_stage2;
        logic sweep;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_opcode op;
        logic    out_free;
        logic    sweep_last;
    } t_stat;

endpackage

[rtl/text_mode_terminal_buffer_core.sv]
// Top level of the text-mode character buffer: a 64x32 cell store with a cursor.
// Depends on tmb_pkg, tmb_ctrl and tmb_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: opcode, char_code,
//   target_col, target_row. Opcodes: put character, move cursor, clear, read cell.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result item per
//   input item, in order: cursor position, cell code, glyph and screen pixel
//   coordinates, glyph_invalid and move_ignored flags.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes cols_in_use
//   (index 0) and rows_in_use (index 1); write only while the block is idle.
// Timing:
//   Items are handled one at a time. Put and move pass through capture and execute;
//   read passes through capture, memory read, divide-by-10 stage, coordinate stage and
//   result load; clear writes space into all 2048 cells through the single memory
//   write port, one cell a cycle.
// Reset:
//   Synchronous, active low. After reset the same sweep fills all 2048 cells
//   with space; o_in_ready stays low until the sweep is done.
// Stalls:
//   The result register lets the next item be accepted while a result waits;
//   if the receiver still holds the slot when the next result is ready, hold
//   that result in its staging registers until the slot frees.
module text_mode_terminal_buffer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [7:0]                     i_char_code,
    input  logic [tmb_pkg::COL_W-1:0]      i_target_col,
    input  logic [tmb_pkg::ROW_W-1:0]      i_target_row,
    // Config writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [tmb_pkg::CFG_COLS_W-1:0] i_cfg_data,
    // Result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tmb_pkg::COL_W-1:0]      o_cursor_col,
    output logic [tmb_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [7:0]                     o_cell_code,
    output logic [6:0]                     o_glyph_src_x,
    output logic [8:0]                     o_glyph_src_y,
    output logic [9:0]                     o_screen_x,
    output logic [8:0]                     o_screen_y,
    output logic                           o_glyph_invalid,
    output logic                           o_move_ignored
);
    import tmb_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    // Config registers take every write; no wait states.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    tmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    tmb_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_valid      (i_in_valid),
        .i_opcode        (i_opcode),
        .i_char_code     (i_char_code),
        .i_target_col    (i_target_col),
        .i_target_row    (i_target_row),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cell_code     (o_cell_code),
        .o_glyph_src_x   (o_glyph_src_x),
        .o_glyph_src_y   (o_glyph_src_y),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_glyph_invalid (o_glyph_invalid),
        .o_move_ignored  (o_move_ignored)
    );

endmodule

[rtl/tmb_ctrl.sv]
// Sequencer of the text buffer core: one item at a time, plus the clear sweep.
// Depends on tmb_pkg; drives the datapath through t_cmd.
module tmb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tmb_pkg::t_stat i_stat,
    output tmb_pkg::t_cmd  o_cmd,
    output logic          o_in_ready
);
    import tmb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_stat.op)
                    OP_READ:  n_state = ST_RD_DATA;
                    OP_CLEAR: n_state = ST_CLEAR;
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_direct = 1'b1;
                            n_state           = ST_IDLE;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                endcase
            end
            ST_RD_DATA: begin
                o_cmd.rd_stage1 = 1'b1;
                n_state         = ST_RD_COORD;
            end
            ST_RD_COORD: begin
                o_cmd.rd_stage2 = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_regs = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

endmodule

[rtl/tmb_datapath.sv]
// Datapath of the text buffer core: cell memory, cursor, config, glyph math, result register.
// Depends on tmb_pkg; steered by tmb_ctrl through t_cmd.
module tmb_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tmb_pkg::t_cmd                i_cmd,
    output tmb_pkg::t_stat               o_stat,
    input  logic                         i_in_valid,
    input  logic [1:0]                   i_opcode,
    input  logic [7:0]                   i_char_code,
    input  logic [tmb_pkg::COL_W-1:0]    i_target_col,
    input  logic [tmb_pkg::ROW_W-1:0]    i_target_row,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [tmb_pkg::CFG_COLS_W-1:0] i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [tmb_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tmb_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [7:0]                   o_cell_code,
    output logic [6:0]                   o_glyph_src_x,
    output logic [8:0]                   o_glyph_src_y,
    output logic [9:0]                   o_screen_x,
    output logic [8:0]                   o_screen_y,
    output logic                         o_glyph_invalid,
    output logic                         o_move_ignored
);
    import tmb_pkg::*;

    // Captured item
    t_opcode          r_op;
    logic [7:0]       r_code;
    logic [COL_W-1:0] r_tcol;
    logic [ROW_W-1:0] r_trow;

    // Config and cursor
    logic [CFG_COLS_W-1:0] r_cols;
    logic [CFG_ROWS_W-1:0] r_rows;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;

    // Sweep address, cell memory
    logic [ADDR_W-1:0] r_clr_addr;
    logic [7:0]        r_mem [CELL_COUNT];
    logic [7:0]        r_rd_data;

    // Staged result
    logic [7:0] r_cell;
    logic       r_inval;
    logic       r_ign;
    logic       r_rd_ok;
    logic [7:0] r_g;
    logic [4:0] r_q;
    logic [6:0] r_gx;
    logic [8:0] r_gy;
    logic [9:0] r_sx;
    logic [8:0] r_sy;

    // Output register
    logic             r_out_valid;
    logic [COL_W-1:0] r_o_col;
    logic [ROW_W-1:0] r_o_row;
    logic [7:0]       r_o_cell;
    logic [6:0]       r_o_gx;
    logic [8:0]       r_o_gy;
    logic [9:0]       r_o_sx;
    logic [8:0]       r_o_sy;
    logic             r_o_inval;
    logic             r_o_ign;

    logic [CFG_COLS_W-1:0] cols_eff;
    logic [CFG_ROWS_W-1:0] rows_eff;
    logic [COL_W:0]        col_inc;
    logic [ROW_W:0]        row_inc;
    logic [ROW_W:0]        row_adv;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      n_row;
    logic                  n_ign;
    logic                  target_in;
    logic                  is_ctrl_char;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [7:0]            mem_wdata;
    logic [7:0]            g_val;
    logic [15:0]           q_prod;
    logic [11:0]           gx_wide;
    logic                  out_free;

    assign cols_eff = (r_cols == '0) ? CFG_COLS_W'(1) :
                      (r_cols > CFG_COLS_W'(MAX_COLS)) ? CFG_COLS_W'(MAX_COLS) : r_cols;
    assign rows_eff = (r_rows == '0) ? CFG_ROWS_W'(1) :
                      (r_rows > CFG_ROWS_W'(MAX_ROWS)) ? CFG_ROWS_W'(MAX_ROWS) : r_rows;

    assign col_inc      = {1'b0, r_col} + 1'b1;
    assign row_inc      = {1'b0, r_row} + 1'b1;
    assign target_in    = ({1'b0, r_tcol} < cols_eff) && ({1'b0, r_trow} < rows_eff);
    assign is_ctrl_char = (r_code == CODE_NL) || (r_code == CODE_CR);

    // Next cursor and move flag for the captured item
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_ign   = 1'b0;
        row_adv = {1'b0, r_row};
        unique case (r_op)
            OP_PUT: begin
                if (r_code == CODE_NL) begin
                    n_row = (row_inc >= rows_eff) ? '0 : row_inc[ROW_W-1:0];
                end else if (r_code == CODE_CR) begin
                    n_col = '0;
                end else begin
                    if (col_inc >= cols_eff) begin
                        n_col   = '0;
                        row_adv = row_inc;
                    end else begin
                        n_col = col_inc[COL_W-1:0];
                    end
                    if (row_adv >= rows_eff) begin
                        n_col = '0;
                        n_row = '0;
                    end else begin
                        n_row = row_adv[ROW_W-1:0];
                    end
                end
            end
            OP_MOVE: begin
                if (target_in) begin
                    n_col = r_tcol;
                    n_row = r_trow;
                end else begin
                    n_ign = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_col = '0;
                n_row = '0;
            end
            OP_READ: begin
                n_col = r_col;
                n_row = r_row;
            end
            default: begin
                n_col = r_col;
                n_row = r_row;
            end
        endcase
    end

    // Single write port: sweep or put
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = CODE_SPACE;
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
        end else if (i_cmd.exec && (r_op == OP_PUT) && !is_ctrl_char) begin
            mem_we    = 1'b1;
            mem_waddr = {r_row, r_col};
            mem_wdata = r_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[{r_trow, r_tcol}];
    end

    // Glyph math: quotient first, then coordinates
    assign g_val   = r_rd_data - CODE_SPACE;
    assign q_prod  = {8'b0, g_val} * 16'(DIV10_MUL);
    assign gx_wide = ({4'b0, r_g} * 12'(GLYPH_W)) - ({7'b0, r_q} * 12'(GLYPH_W * SHEET_PER_ROW));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_opcode'(i_opcode);
            r_code <= i_char_code;
            r_tcol <= i_target_col;
            r_trow <= i_target_row;
        end
        if (i_cmd.exec) begin
            r_ign   <= n_ign;
            r_rd_ok <= target_in;
            r_cell  <= '0;
            r_inval <= 1'b0;
            r_gx    <= '0;
            r_gy    <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
        end
        if (i_cmd.rd_stage1) begin
            r_cell  <= r_rd_ok ? r_rd_data : 8'd0;
            r_inval <= !r_rd_ok || (r_rd_data < CODE_SPACE);
            r_g     <= g_val;
            r_q     <= q_prod[DIV10_SHIFT +: 5];
        end
        if (i_cmd.rd_stage2 && !r_inval) begin
            r_gx <= gx_wide[6:0];
            r_gy <= {4'b0, r_q} * 9'(GLYPH_H);
            r_sx <= {4'b0, r_tcol} * 10'(GLYPH_W);
            r_sy <= {4'b0, r_trow} * 9'(GLYPH_H);
        end
    end

    // Control state: config, cursor, sweep address, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= CFG_COLS_W'(MAX_COLS);
            r_rows      <= CFG_ROWS_W'(MAX_ROWS);
            r_col       <= '0;
            r_row       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COLS: r_cols <= i_cfg_data;
                    CFG_ROWS: r_rows <= i_cfg_data[CFG_ROWS_W-1:0];
                    default:  r_cols <= r_cols;
                endcase
            end
            if (i_cmd.exec) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.sweep) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load_direct || i_cmd.load_regs) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_o_col   <= n_col;
            r_o_row   <= n_row;
            r_o_cell  <= '0;
            r_o_gx    <= '0;
            r_o_gy    <= '0;
            r_o_sx    <= '0;
            r_o_sy    <= '0;
            r_o_inval <= 1'b0;
            r_o_ign   <= n_ign;
        end else if (i_cmd.load_regs) begin
            r_o_col   <= r_col;
            r_o_row   <= r_row;
            r_o_cell  <= r_cell;
            r_o_gx    <= r_gx;
            r_o_gy    <= r_gy;
            r_o_sx    <= r_sx;
            r_o_sy    <= r_sy;
            r_o_inval <= r_inval;
            r_o_ign   <= r_ign;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.in_valid   = i_in_valid;
    assign o_stat.op         = r_op;
    assign o_stat.out_free   = out_free;
    assign o_stat.sweep_last = (r_clr_addr == {ADDR_W{1'b1}});

    assign o_out_valid     = r_out_valid;
    assign o_cursor_col    = r_o_col;
    assign o_cursor_row    = r_o_row;
    assign o_cell_code     = r_o_cell;
    assign o_glyph_src_x   = r_o_gx;
    assign o_glyph_src_y   = r_o_gy;
    assign o_screen_x      = r_o_sx;
    assign o_screen_y      = r_o_sy;
    assign o_glyph_invalid = r_o_inval;
    assign o_move_ignored  = r_o_ign;

endmodule

[rtl/tmb_checker.sv]
// Port-level checks for the text buffer core, bound to the top level.
// Depends on text_mode_terminal_buffer_core_macros.svh.
`include "text_mode_terminal_buffer_core_macros.svh"

module tmb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_cell_code,
    input logic [6:0] o_glyph_src_x,
    input logic [8:0] o_glyph_src_y,
    input logic [9:0] o_screen_x,
    input logic [8:0] o_screen_y,
    input logic       o_glyph_invalid,
    input logic       o_move_ignored
);

    // A pending result is held until taken.
    `TMB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Items are handled one at a time: no accept right after an accept.
    `TMB_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // The memory clearing sweep blocks input when reset is released.
    `TMB_ASSERT_NOW(a_init_sweep, i_clk, i_rst_n, $rose(i_rst_n), !o_in_ready)

    // An invalid glyph carries no coordinates.
    `TMB_ASSERT_NOW(a_inval_zero, i_clk, i_rst_n, o_out_valid && o_glyph_invalid, (o_glyph_src_x == 7'd0) && (o_glyph_src_y == 9'd0) && (o_screen_x == 10'd0) && (o_screen_y == 9'd0))

    // An ignored move is not a read.
    `TMB_ASSERT_NOW(a_move_not_read, i_clk, i_rst_n, o_out_valid && o_move_ignored, (o_cell_code == 8'd0) && !o_glyph_invalid)

endmodule

bind text_mode_terminal_buffer_core tmb_checker u_tmb_checker (.*);

[bench/tmb_bench_pkg.sv]
// Scoreboard for the text buffer core bench: screen and cursor predictor plus result check.
// Depends on tmb_pkg for widths, codes and the opcode enum.
package tmb_bench_pkg;
    import tmb_pkg::*;

    typedef struct packed {
        t_opcode          op;
        logic [7:0]       code;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_command;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       cell_code;
        logic [6:0]       glyph_src_x;
        logic [8:0]       glyph_src_y;
        logic [9:0]       screen_x;
        logic [8:0]       screen_y;
        logic             glyph_invalid;
        logic             move_ignored;
    } t_result;

    class screen_scoreboard;
        logic [7:0]            cells [CELL_COUNT];
        int                    cur_col;
        int                    cur_row;
        logic [CFG_COLS_W-1:0] cols_reg;
        logic [CFG_ROWS_W-1:0] rows_reg;
        t_result               pending_results [$];
        int                    error_count;
        int                    result_count;

        function new();
            cols_reg     = 7'd64;
            rows_reg     = 6'd32;
            error_count  = 0;
            result_count = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (cells[i]) cells[i] = CODE_SPACE;
            cur_col = 0;
            cur_row = 0;
        endfunction

        // Zero acts as one, anything past the grid acts as the grid size.
        function int screen_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return int'(cols_reg);
        endfunction

        function int screen_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return int'(rows_reg);
        endfunction

        function void write_register(logic index, logic [CFG_COLS_W-1:0] data);
            if (index == CFG_COLS) cols_reg = data;
            else rows_reg = data[CFG_ROWS_W-1:0];
        endfunction

        function t_result apply_command(t_command c);
            t_result    r;
            int         cols;
            int         rows;
            int         tc;
            int         tr;
            int         g;
            logic [7:0] stored;
            r    = '0;
            cols = screen_cols();
            rows = screen_rows();
            tc   = int'(c.col);
            tr   = int'(c.row);
            case (c.op)
                OP_PUT: begin
                    if (c.code == CODE_NL) begin
                        cur_row++;
                        if (cur_row >= rows) cur_row = 0;
                    end else if (c.code == CODE_CR) begin
                        cur_col = 0;
                    end else begin
                        cells[cur_row * MAX_COLS + cur_col] = c.code;
                        cur_col++;
                        if (cur_col >= cols) begin
                            cur_col = 0;
                            cur_row++;
                        end
                        if (cur_row >= rows) begin
                            cur_col = 0;
                            cur_row = 0;
                        end
                    end
                end
                OP_MOVE: begin
                    if (tc < cols && tr < rows) begin
                        cur_col = tc;
                        cur_row = tr;
                    end else begin
                        r.move_ignored = 1'b1;
                    end
                end
                OP_CLEAR: wipe();
                default: begin
                    if (tc < cols && tr < rows) begin
                        stored      = cells[tr * MAX_COLS + tc];
                        r.cell_code = stored;
                        if (stored < CODE_SPACE) begin
                            r.glyph_invalid = 1'b1;
                        end else begin
                            g             = int'(stored) - int'(CODE_SPACE);
                            r.glyph_src_x = 7'((g % SHEET_PER_ROW) * GLYPH_W);
                            r.glyph_src_y = 9'((g / SHEET_PER_ROW) * GLYPH_H);
                            r.screen_x    = 10'(tc * GLYPH_W);
                            r.screen_y    = 9'(tr * GLYPH_H);
                        end
                    end else begin
                        r.glyph_invalid = 1'b1;
                    end
                end
            endcase
            r.cursor_col = cur_col[COL_W-1:0];
            r.cursor_row = cur_row[ROW_W-1:0];
            return r;
        endfunction

        function void note_command(t_command c);
            pending_results.push_back(apply_command(c));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at result %0d: %s", result_count, msg);
            error_count++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item pending");
                result_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("cursor_col", got.cursor_col, want.cursor_col);
            check_field("cursor_row", got.cursor_row, want.cursor_row);
            check_field("cell_code", got.cell_code, want.cell_code);
            check_field("glyph_src_x", got.glyph_src_x, want.glyph_src_x);
            check_field("glyph_src_y", got.glyph_src_y, want.glyph_src_y);
            check_field("screen_x", got.screen_x, want.screen_x);
            check_field("screen_y", got.screen_y, want.screen_y);
            check_field("glyph_invalid", got.glyph_invalid, want.glyph_invalid);
            check_field("move_ignored", got.move_ignored, want.move_ignored);
            result_count++;
        endtask
    endclass

endpackage

[bench/tb_top.sv]
// Top-level bench of the text buffer core: drives items and register writes, checks results.
// Depends on tmb_pkg, tmb_bench_pkg and the text_mode_terminal_buffer_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmb_pkg::*;
    import tmb_bench_pkg::*;

    // Longest quiet stretch in a correct run is the sweep after reset or a clear,
    // plus idling on either side.
    localparam int IDLE_LIMIT      = 10000;
    localparam int TAIL_CYCLES     = 20;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int FIXED_PHASES    = 8;
    localparam int PHASES          = 10;

    // Screen settings per fixed phase; zero and oversize values check clamping,
    // rows data above 63 checks that only six bits are kept.
    localparam int COL_SETTINGS [FIXED_PHASES] = '{64, 1, 5, 0, 127, 20, 2, 64};
    localparam int ROW_SETTINGS [FIXED_PHASES] = '{32, 1, 3, 0, 63, 96, 32, 1};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_opcode;
    logic [7:0]            i_char_code;
    logic [COL_W-1:0]      i_target_col;
    logic [ROW_W-1:0]      i_target_row;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [CFG_COLS_W-1:0] i_cfg_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [COL_W-1:0]      o_cursor_col;
    logic [ROW_W-1:0]      o_cursor_row;
    logic [7:0]            o_cell_code;
    logic [6:0]            o_glyph_src_x;
    logic [8:0]            o_glyph_src_y;
    logic [9:0]            o_screen_x;
    logic [8:0]            o_screen_y;
    logic                  o_glyph_invalid;
    logic                  o_move_ignored;

    screen_scoreboard sb = new();
    // Set by the stimulus for stretches where neither side idles.
    logic             no_gaps = 1'b0;
    int               idle_cycles = 0;

    text_mode_terminal_buffer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_char_code     (i_char_code),
        .i_target_col    (i_target_col),
        .i_target_row    (i_target_row),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cell_code     (o_cell_code),
        .o_glyph_src_x   (o_glyph_src_x),
        .o_glyph_src_y   (o_glyph_src_y),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_glyph_invalid (o_glyph_invalid),
        .o_move_ignored  (o_move_ignored)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: restart the count on any handshake, bail out when the block goes quiet.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: unless no_gaps is set, ready may drop for a random gap before each
    // item; then hold ready until one is taken, and check it against the oldest prediction.
    initial begin
        int      gap;
        t_result got;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got.cursor_col    = o_cursor_col;
            got.cursor_row    = o_cursor_row;
            got.cell_code     = o_cell_code;
            got.glyph_src_x   = o_glyph_src_x;
            got.glyph_src_y   = o_glyph_src_y;
            got.screen_x      = o_screen_x;
            got.screen_y      = o_screen_y;
            got.glyph_invalid = o_glyph_invalid;
            got.move_ignored  = o_move_ignored;
            sb.check_result(got);
            @(negedge i_clk);
        end
    end

    // Enter and leave at a falling edge. With no gap, valid stays high and only the
    // payload moves, so valid gets one assignment per step.
    task automatic send_command(t_command c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= c.op;
        i_char_code  <= c.code;
        i_target_col <= c.col;
        i_target_row <= c.row;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic send_op(t_opcode op, int code, int col, int row);
        t_command c;
        c.op   = op;
        c.code = 8'(code);
        c.col  = 6'(col);
        c.row  = 5'(row);
        send_command(c);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_register(logic index, logic [CFG_COLS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.write_register(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Resize the screen only once the block is idle; vary the write order.
    task automatic configure(int cols, int rows);
        drain_results();
        if ($urandom_range(0, 1) == 1) begin
            write_register(CFG_COLS, 7'(cols));
            write_register(CFG_ROWS, 7'(rows));
        end else begin
            write_register(CFG_ROWS, 7'(rows));
            write_register(CFG_COLS, 7'(cols));
        end
    endtask

    // Mostly typing with reads near the cursor; moves, clears and wild targets
    // mixed in. Unused fields stay random so every bit toggles.
    function automatic t_command draw_command();
        t_command c;
        int       cols;
        int       rows;
        int       r;
        int       pick;
        cols   = sb.screen_cols();
        rows   = sb.screen_rows();
        c.code = 8'($urandom_range(0, 255));
        c.col  = 6'($urandom_range(0, 63));
        c.row  = 5'($urandom_range(0, 31));
        r      = $urandom_range(0, 99);
        pick   = $urandom_range(0, 99);
        if (r < 3) begin
            c.op = OP_CLEAR;
        end else if (r < 55) begin
            c.op = OP_PUT;
            if (pick < 8) c.code = CODE_NL;
            else if (pick < 16) c.code = CODE_CR;
            else if (pick < 70) c.code = 8'($urandom_range(32, 126));
        end else if (r < 70) begin
            c.op = OP_MOVE;
            if (pick < 75) begin
                c.col = 6'($urandom_range(0, cols - 1));
                c.row = 5'($urandom_range(0, rows - 1));
            end
        end else begin
            c.op = OP_READ;
            if (pick < 40) begin
                // cell just typed, or the cursor cell at column zero
                c.col = 6'(sb.cur_col == 0 ? 0 : sb.cur_col - 1);
                c.row = 5'(sb.cur_row);
            end else if (pick < 80) begin
                c.col = 6'($urandom_range(0, cols - 1));
                c.row = 5'($urandom_range(0, rows - 1));
            end
        end
        return c;
    endfunction

    initial begin
        int cols;
        int rows;
        int pause_at;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_PUT;
        i_char_code  = '0;
        i_target_col = '0;
        i_target_row = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_COLS;
        i_cfg_data   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the space-fill sweep that follows reset
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);

        // Full 64x32 screen: code extremes, glyph sheet corners, last-cell wrap.
        send_op(OP_PUT, 8'h41, 0, 0);
        send_op(OP_PUT, 8'h00, 0, 0);
        send_op(OP_PUT, 8'hff, 0, 0);
        send_op(OP_PUT, 8'h1f, 0, 0);
        send_op(OP_PUT, CODE_SPACE, 0, 0);
        send_op(OP_READ, 0, 0, 0);
        send_op(OP_READ, 0, 1, 0);
        send_op(OP_READ, 0, 2, 0);
        send_op(OP_READ, 0, 3, 0);
        send_op(OP_READ, 0, 4, 0);
        send_op(OP_READ, 0, 63, 31);
        send_op(OP_MOVE, 0, 63, 31);
        send_op(OP_PUT, 8'h7a, 0, 0);
        send_op(OP_MOVE, 0, 63, 5);
        send_op(OP_PUT, 8'h7e, 0, 0);
        send_op(OP_MOVE, 0, 10, 3);
        send_op(OP_PUT, CODE_CR, 0, 0);
        send_op(OP_MOVE, 0, 7, 31);
        send_op(OP_PUT, CODE_NL, 0, 0);
        send_op(OP_READ, 0, 63, 31);

        // Shrink to 5x3 with the cursor left far outside the new screen.
        send_op(OP_MOVE, 0, 40, 20);
        configure(5, 3);
        send_op(OP_PUT, CODE_NL, 0, 0);
        send_op(OP_PUT, 8'h51, 0, 0);
        send_op(OP_MOVE, 0, 5, 0);
        send_op(OP_MOVE, 0, 0, 3);
        send_op(OP_READ, 0, 5, 0);
        send_op(OP_MOVE, 0, 4, 2);
        send_op(OP_PUT, 8'h78, 0, 0);
        // Grow back: the code stored off screen must still be there, until a clear.
        configure(64, 32);
        send_op(OP_READ, 0, 40, 0);
        send_op(OP_CLEAR, 0, 0, 0);
        send_op(OP_READ, 0, 40, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < FIXED_PHASES) begin
                cols = COL_SETTINGS[phase];
                rows = ROW_SETTINGS[phase];
            end else begin
                cols = $urandom_range(0, 127);
                rows = $urandom_range(0, 127);
            end
            configure(cols, rows);
            pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 28 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                if (n == pause_at) drain_results();
                send_command(draw_command());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tmb_pkg.sv
rtl/tmb_ctrl.sv
rtl/tmb_datapath.sv
rtl/text_mode_terminal_buffer_core.sv
rtl/tmb_checker.sv
bench/tmb_bench_pkg.sv
bench/tb_top.sv
